@@ src/cc20_pkg.sv @@
// shared types, constants and helpers for the chacha20 stream cipher unit
package cc20_pkg;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] ks_state_t;

  // block function constants ("expand 32-byte k")
  localparam word_t SIGMA_0 = 32'h61707865;
  localparam word_t SIGMA_1 = 32'h3320646e;
  localparam word_t SIGMA_2 = 32'h79622d32;
  localparam word_t SIGMA_3 = 32'h6b206574;

  // half quarter-round steps: 10 double rounds, 4 half steps each
  localparam int unsigned ROUND_STEPS = 40;
  localparam int unsigned STEP_W = 6;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LO  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HI  = 3'd5;

  // control sequencer of the top level
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GEN,
    ST_XOR
  } ctl_state_e;

  // keystream core sequencer
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_RUN,
    CS_ADD
  } core_state_e;

  // core status toward the control sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } core_status_t;

  function automatic word_t rotl(word_t v, int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

endpackage

@@ src/chacha20_stream_cipher_unit.sv @@
// chacha20 stream cipher unit top level: config, word sequencing, xor and output register
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, data_in_i, byte_count_i,     | to unit
//          | last_i                                               |
//  out     | out_valid_o, out_stall_i, data_out_o,                | from unit
//          | byte_count_out_o, last_out_o, counter_overflow_o     |
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i    | to unit
//
// the first word of each 64-byte block goes through accept, 40 half-round
// steps of the shared round unit, one feed-forward add, one done handoff, then xor.
// other words go through accept, then xor into the output register.
// one word is in flight at a time; in_stall_o is high until its result is
// loaded into the output register, which then waits for out_stall_i low.
// reset clears key, nonce, block counter, word position and overflow flag.
module chacha20_stream_cipher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] data_in_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] data_out_o,
  output logic [3:0]  byte_count_out_o,
  output logic        last_out_o,
  output logic        counter_overflow_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [cc20_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  cc20_pkg::ctl_state_e state_q, state_d;
  logic [63:0] key0_q, key1_q, key2_q, key3_q, nonce_lo_q;
  logic [31:0] nonce_hi_q;
  logic [31:0] ctr_q, ctr_d;
  logic [2:0]  pos_q, pos_d;
  logic        ovf_q, ovf_d;
  logic [63:0] data_q;
  logic [3:0]  count_q;
  logic        last_q;
  logic        out_valid_q, out_valid_d;
  logic [63:0] data_out_q, data_out_d;
  logic [3:0]  count_out_q;
  logic        last_out_q, ovf_out_q;
  logic        in_fire, out_free, load_out, core_start;
  cc20_pkg::ks_state_t   init_blk, ks_blk;
  cc20_pkg::core_status_t core_status;
  logic [63:0] ks_word, byte_mask;

  assign in_stall_o  = (state_q != cc20_pkg::ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign load_out    = (state_q == cc20_pkg::ST_XOR) && out_free;
  assign core_start  = in_fire && (pos_q == 3'd0);
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q     <= '0;
      key1_q     <= '0;
      key2_q     <= '0;
      key3_q     <= '0;
      nonce_lo_q <= '0;
      nonce_hi_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        cc20_pkg::CFG_KEY_0:    key0_q     <= cfg_data_i;
        cc20_pkg::CFG_KEY_1:    key1_q     <= cfg_data_i;
        cc20_pkg::CFG_KEY_2:    key2_q     <= cfg_data_i;
        cc20_pkg::CFG_KEY_3:    key3_q     <= cfg_data_i;
        cc20_pkg::CFG_NONCE_LO: nonce_lo_q <= cfg_data_i;
        cc20_pkg::CFG_NONCE_HI: nonce_hi_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // block function input words
  always_comb begin
    init_blk[0]  = cc20_pkg::SIGMA_0;
    init_blk[1]  = cc20_pkg::SIGMA_1;
    init_blk[2]  = cc20_pkg::SIGMA_2;
    init_blk[3]  = cc20_pkg::SIGMA_3;
    init_blk[4]  = key0_q[31:0];
    init_blk[5]  = key0_q[63:32];
    init_blk[6]  = key1_q[31:0];
    init_blk[7]  = key1_q[63:32];
    init_blk[8]  = key2_q[31:0];
    init_blk[9]  = key2_q[63:32];
    init_blk[10] = key3_q[31:0];
    init_blk[11] = key3_q[63:32];
    init_blk[12] = ctr_q;
    init_blk[13] = nonce_lo_q[31:0];
    init_blk[14] = nonce_lo_q[63:32];
    init_blk[15] = nonce_hi_q;
  end

  cc20_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (core_start),
    .init_i   (init_blk),
    .status_o (core_status),
    .ks_o     (ks_blk)
  );

  // keystream slice and byte mask for the held word
  always_comb begin
    ks_word = {ks_blk[{pos_q, 1'b1}], ks_blk[{pos_q, 1'b0}]};
    for (int k = 0; k < 8; k++) begin
      byte_mask[8*k +: 8] = (count_q > 4'(k)) ? 8'hff : 8'h00;
    end
    data_out_d = (data_q ^ ks_word) & byte_mask;
  end

  // control sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cc20_pkg::ST_IDLE;
      ctr_q       <= '0;
      pos_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctr_q       <= ctr_d;
      pos_q       <= pos_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctr_d       = ctr_q;
    pos_d       = pos_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      cc20_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = core_start ? cc20_pkg::ST_GEN : cc20_pkg::ST_XOR;
        end
      end
      cc20_pkg::ST_GEN: begin
        if (core_status.done) begin
          state_d = cc20_pkg::ST_XOR;
        end
      end
      cc20_pkg::ST_XOR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          pos_d       = pos_q + 1'b1;
          state_d     = cc20_pkg::ST_IDLE;
          if (pos_q == 3'd7) begin
            ctr_d = ctr_q + 1'b1;
            if (ctr_q == '1) begin
              ovf_d = 1'b1;
            end
          end
          if (last_q) begin
            ctr_d = '0;
            pos_d = '0;
            ovf_d = 1'b0;
          end
        end
      end
      default: state_d = cc20_pkg::ST_IDLE;
    endcase
  end

  // held input transaction
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      data_q  <= data_in_i;
      count_q <= byte_count_i;
      last_q  <= last_i;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      data_out_q  <= data_out_d;
      count_out_q <= count_q;
      last_out_q  <= last_q;
      ovf_out_q   <= ovf_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign data_out_o         = data_out_q;
  assign byte_count_out_o   = count_out_q;
  assign last_out_o         = last_out_q;
  assign counter_overflow_o = ovf_out_q;

  // keystream generation only starts at the first word of a block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_status.busy |-> (pos_q == 3'd0) && (state_q == cc20_pkg::ST_GEN))
    else $error("core busy outside a block start");

  // the end of a message clears the block sequencing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && last_q) |=> (pos_q == 3'd0) && (ctr_q == '0) && !ovf_q)
    else $error("message end did not clear the block sequencing");

  // the word position only moves when a result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load_out |=> $stable(pos_q) && $stable(ctr_q))
    else $error("word position moved without a result");

  // a stalled result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !load_out)
    else $error("output register overwritten while stalled");

endmodule

@@ src/cc20_round.sv @@
// shared half quarter-round unit, four lanes over the 16-word state
module cc20_round (
  input  cc20_pkg::ks_state_t x_i,
  input  logic                diag_i,
  input  logic                phase_i,
  output cc20_pkg::ks_state_t y_o
);

  logic [3:0] ai, bi, ci, di;
  cc20_pkg::word_t a_sum, d_mix, c_sum, b_mix;

  // lane j works on a column (diag_i low) or a diagonal (diag_i high)
  always_comb begin
    y_o = x_i;
    ai = '0;
    bi = '0;
    ci = '0;
    di = '0;
    a_sum = '0;
    d_mix = '0;
    c_sum = '0;
    b_mix = '0;
    for (int j = 0; j < 4; j++) begin
      ai = 4'(j);
      bi = {2'b01, 2'(j) + (diag_i ? 2'd1 : 2'd0)};
      ci = {2'b10, 2'(j) + (diag_i ? 2'd2 : 2'd0)};
      di = {2'b11, 2'(j) + (diag_i ? 2'd3 : 2'd0)};
      a_sum = x_i[ai] + x_i[bi];
      d_mix = phase_i ? cc20_pkg::rotl(x_i[di] ^ a_sum, 8)
                      : cc20_pkg::rotl(x_i[di] ^ a_sum, 16);
      c_sum = x_i[ci] + d_mix;
      b_mix = phase_i ? cc20_pkg::rotl(x_i[bi] ^ c_sum, 7)
                      : cc20_pkg::rotl(x_i[bi] ^ c_sum, 12);
      y_o[ai] = a_sum;
      y_o[bi] = b_mix;
      y_o[ci] = c_sum;
      y_o[di] = d_mix;
    end
  end

endmodule

@@ src/cc20_core.sv @@
// keystream block generator: sequencer around the shared round unit
module cc20_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  cc20_pkg::ks_state_t   init_i,
  output cc20_pkg::core_status_t status_o,
  output cc20_pkg::ks_state_t   ks_o
);

  cc20_pkg::core_state_e state_q, state_d;
  logic [cc20_pkg::STEP_W-1:0] step_q, step_d;
  logic done_q, done_d;
  cc20_pkg::ks_state_t x_q, x_d;
  cc20_pkg::ks_state_t ks_q, ks_d;
  cc20_pkg::ks_state_t round_y;

  // step bit 0 picks the half, bit 1 picks column or diagonal
  cc20_round u_round (
    .x_i     (x_q),
    .diag_i  (step_q[1]),
    .phase_i (step_q[0]),
    .y_o     (round_y)
  );

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cc20_pkg::CS_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  // working state and finished keystream
  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    ks_q <= ks_d;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    done_d  = 1'b0;
    x_d     = x_q;
    ks_d    = ks_q;
    unique case (state_q)
      cc20_pkg::CS_IDLE: begin
        if (start_i) begin
          x_d     = init_i;
          step_d  = '0;
          state_d = cc20_pkg::CS_RUN;
        end
      end
      cc20_pkg::CS_RUN: begin
        x_d    = round_y;
        step_d = step_q + 1'b1;
        if (step_q == cc20_pkg::STEP_W'(cc20_pkg::ROUND_STEPS - 1)) begin
          state_d = cc20_pkg::CS_ADD;
        end
      end
      cc20_pkg::CS_ADD: begin
        // feed-forward of the input words
        for (int i = 0; i < 16; i++) begin
          ks_d[i] = x_q[i] + init_i[i];
        end
        done_d  = 1'b1;
        state_d = cc20_pkg::CS_IDLE;
      end
      default: state_d = cc20_pkg::CS_IDLE;
    endcase
  end

  assign status_o.busy = (state_q != cc20_pkg::CS_IDLE);
  assign status_o.done = done_q;
  assign ks_o = ks_q;

endmodule
